>>> rtl/core/assert_macros.svh
// Assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define ASSERT_NOW(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mfvss_pkg.sv
package mfvss_pkg;

	localparam int NUM_VOICES_DEF = 4;
	localparam int NOTE_COUNT     = 128;
	localparam int NOTE_W         = 7;
	localparam int STEP_W         = 16;
	localparam int LEVEL_W        = 6;
	localparam int SAMPLE_W       = 8;
	localparam int BUSY_OUT_W     = 4;
	localparam int PROD_W         = SAMPLE_W + LEVEL_W;

	localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
	localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;

	// Phase increment per tick for each MIDI note
	localparam logic [STEP_W-1:0] RATE_ROM [NOTE_COUNT] = '{
		16'd11, 16'd11, 16'd12, 16'd13, 16'd14, 16'd14, 16'd15, 16'd16,
		16'd17, 16'd18, 16'd19, 16'd20, 16'd21, 16'd23, 16'd24, 16'd25,
		16'd27, 16'd29, 16'd30, 16'd32, 16'd34, 16'd36, 16'd38, 16'd40,
		16'd43, 16'd45, 16'd48, 16'd51, 16'd54, 16'd57, 16'd61, 16'd64,
		16'd68, 16'd72, 16'd76, 16'd81, 16'd86, 16'd91, 16'd96, 16'd102,
		16'd108, 16'd114, 16'd121, 16'd128, 16'd136, 16'd144, 16'd153, 16'd162,
		16'd171, 16'd182, 16'd192, 16'd204, 16'd216, 16'd229, 16'd242, 16'd257,
		16'd272, 16'd288, 16'd306, 16'd324, 16'd343, 16'd363, 16'd385, 16'd408,
		16'd432, 16'd458, 16'd485, 16'd514, 16'd544, 16'd577, 16'd611, 16'd647,
		16'd686, 16'd727, 16'd770, 16'd816, 16'd864, 16'd915, 16'd970, 16'd1028,
		16'd1089, 16'd1153, 16'd1222, 16'd1295, 16'd1372, 16'd1453, 16'd1540, 16'd1631,
		16'd1728, 16'd1831, 16'd1940, 16'd2055, 16'd2177, 16'd2307, 16'd2444, 16'd2589,
		16'd2743, 16'd2906, 16'd3079, 16'd3262, 16'd3456, 16'd3662, 16'd3880, 16'd4110,
		16'd4355, 16'd4614, 16'd4888, 16'd5179, 16'd5487, 16'd5813, 16'd6159, 16'd6525,
		16'd6913, 16'd7324, 16'd7759, 16'd8221, 16'd8710, 16'd9227, 16'd9776, 16'd10357,
		16'd10973, 16'd11626, 16'd12317, 16'd13050, 16'd13826, 16'd14648, 16'd15519, 16'd16441
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SUM,
		ST_MSG
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PS_CMD,
		PS_NOTE,
		PS_VEL
	} parse_state_t;

	// Decode of the incoming byte
	typedef struct packed {
		logic cmd_on;
		logic cmd_off;
		logic data_hi;
	} byte_stat_t;

	typedef struct packed {
		logic out_load;
		logic mix_clr;
		logic load_note;
		logic load_vel;
		logic apply_msg;
		logic note_on;
		logic voice_step;
		logic mix_add;
		logic commit;
	} dp_cmd_t;

endpackage

>>> rtl/core/mfvss_ram.sv
module mfvss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/mfvss_dp.sv
module mfvss_dp #(
	parameter int NUM_VOICES = mfvss_pkg::NUM_VOICES_DEF,
	parameter int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mfvss_pkg::dp_cmd_t                  cmd,
	input  logic [VIDX_W-1:0]                   voice_idx,
	input  logic [7:0]                          midi_byte,
	output mfvss_pkg::byte_stat_t               stat,
	output logic [mfvss_pkg::SAMPLE_W-1:0]      sample_out,
	output logic [mfvss_pkg::BUSY_OUT_W-1:0]    busy_voices
);

	import mfvss_pkg::*;

	// owner code: 0 = free, else voice + 1
	localparam int OW = $clog2(NUM_VOICES + 1);

	logic [STEP_W-1:0]   acc_q   [NUM_VOICES];
	logic [STEP_W-1:0]   step_q  [NUM_VOICES];
	logic [LEVEL_W-1:0]  level_q [NUM_VOICES];
	logic [NUM_VOICES-1:0] en_q;
	logic [NUM_VOICES-1:0] busy_q;
	logic [NOTE_COUNT-1:0] note_vld_q;

	logic [NOTE_W-1:0]   held_note_q;
	logic [LEVEL_W-1:0]  vel_q;
	logic [SAMPLE_W-1:0] held_sample_q;
	logic [SAMPLE_W-1:0] mix_q;
	logic [PROD_W-1:0]   prod_s1;
	logic [SAMPLE_W-1:0] sample_out_q;
	logic [BUSY_OUT_W-1:0] busy_out_q;

	logic [OW-1:0]       ram_rdata;
	logic [OW-1:0]       owner;
	logic [OW-1:0]       owner_m1;
	logic [VIDX_W-1:0]   owner_v;
	logic                free_found;
	logic [VIDX_W-1:0]   free_v;
	logic                do_on;
	logic                do_off;
	logic [STEP_W-1:0]   phase_nxt;
	logic [SAMPLE_W-1:0] phase_hi;
	logic [SAMPLE_W-1:0] prod_top;
	logic [BUSY_OUT_W-1:0] busy_pad;

	assign stat.cmd_on  = (midi_byte == MIDI_NOTE_ON);
	assign stat.cmd_off = (midi_byte == MIDI_NOTE_OFF);
	assign stat.data_hi = midi_byte[7];

	mfvss_ram #(
		.WIDTH (OW),
		.DEPTH (NOTE_COUNT)
	) u_owner_ram (
		.clk   (clk),
		.we    (do_on),
		.waddr (held_note_q),
		.wdata (OW'(free_v) + OW'(1)),
		.raddr (held_note_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		owner    = note_vld_q[held_note_q] ? ram_rdata : '0;
		owner_m1 = owner - OW'(1);
		owner_v  = owner_m1[VIDX_W-1:0];
		// last free voice found wins: highest-numbered
		free_found = 1'b0;
		free_v     = '0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			if (!busy_q[v]) begin
				free_found = 1'b1;
				free_v     = VIDX_W'(v);
			end
		end
		do_on  = cmd.apply_msg && cmd.note_on && (owner == '0) && free_found;
		do_off = cmd.apply_msg && !cmd.note_on && (owner != '0);
	end

	assign phase_nxt = acc_q[voice_idx] + step_q[voice_idx];
	assign phase_hi  = en_q[voice_idx] ? phase_nxt[STEP_W-1 -: SAMPLE_W] : '0;
	assign prod_top  = SAMPLE_W'(prod_s1[PROD_W-1:SAMPLE_W]);

	always_comb begin
		busy_pad = '0;
		for (int i = 0; i < NUM_VOICES && i < BUSY_OUT_W; i++) begin
			busy_pad[i] = busy_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				acc_q[v]   <= '0;
				step_q[v]  <= '0;
				level_q[v] <= '0;
			end
			en_q          <= '0;
			busy_q        <= '0;
			note_vld_q    <= '0;
			held_note_q   <= '0;
			held_sample_q <= '0;
			sample_out_q  <= '0;
			busy_out_q    <= '0;
		end else begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (cmd.voice_step && voice_idx == VIDX_W'(v)) begin
					acc_q[v] <= phase_nxt;
				end
				if (do_off && owner_v == VIDX_W'(v)) begin
					acc_q[v]   <= '0;
					step_q[v]  <= '0;
					level_q[v] <= '0;
					en_q[v]    <= 1'b0;
					busy_q[v]  <= 1'b0;
				end
				if (do_on && free_v == VIDX_W'(v)) begin
					step_q[v]  <= RATE_ROM[held_note_q];
					level_q[v] <= vel_q;
					en_q[v]    <= 1'b1;
					busy_q[v]  <= 1'b1;
				end
			end
			if (do_on) begin
				note_vld_q[held_note_q] <= 1'b1;
			end
			if (do_off) begin
				note_vld_q[held_note_q] <= 1'b0;
			end
			if (cmd.load_note) begin
				held_note_q <= midi_byte[NOTE_W-1:0];
			end
			if (cmd.commit) begin
				held_sample_q <= mix_q + prod_top;
			end
			if (cmd.out_load) begin
				sample_out_q <= held_sample_q;
				busy_out_q   <= busy_pad;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vel) begin
			vel_q <= midi_byte[LEVEL_W:1];
		end
		if (cmd.voice_step) begin
			prod_s1 <= phase_hi * level_q[voice_idx];
		end
		if (cmd.mix_clr) begin
			mix_q <= '0;
		end else if (cmd.mix_add) begin
			mix_q <= mix_q + prod_top;
		end
	end

	assign sample_out  = sample_out_q;
	assign busy_voices = busy_out_q;

endmodule

>>> rtl/core/mfvss_ctrl.sv
module mfvss_ctrl #(
	parameter int NUM_VOICES = mfvss_pkg::NUM_VOICES_DEF,
	parameter int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  op,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  mfvss_pkg::byte_stat_t stat,
	output mfvss_pkg::dp_cmd_t    cmd,
	output logic [VIDX_W-1:0]     voice_idx
);

	import mfvss_pkg::*;

	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

	ctrl_state_t  state_q, state_d;
	parse_state_t parse_q, parse_d;
	logic         note_on_q, note_on_d;
	logic [VIDX_W-1:0] idx_q, idx_d;
	logic         out_valid_q, out_valid_d;
	logic         accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			parse_q     <= PS_CMD;
			note_on_q   <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			parse_q     <= parse_d;
			note_on_q   <= note_on_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// a tick needs the output register free, or emptying this cycle
	assign in_stall  = (state_q != ST_IDLE) || (!op && out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign voice_idx = idx_q;

	always_comb begin
		state_d     = state_q;
		parse_d     = parse_q;
		note_on_d   = note_on_q;
		idx_d       = idx_q;
		cmd         = '0;
		cmd.note_on = note_on_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept && !op) begin
					cmd.out_load = 1'b1;
					cmd.mix_clr  = 1'b1;
					idx_d        = '0;
					state_d      = ST_TICK;
				end else if (accept) begin
					unique case (parse_q)
						PS_CMD: begin
							if (stat.cmd_on || stat.cmd_off) begin
								note_on_d = stat.cmd_on;
								parse_d   = PS_NOTE;
							end
						end
						PS_NOTE: begin
							if (stat.data_hi) begin
								parse_d = PS_CMD;
							end else begin
								cmd.load_note = 1'b1;
								parse_d       = PS_VEL;
							end
						end
						PS_VEL: begin
							parse_d = PS_CMD;
							if (!stat.data_hi) begin
								cmd.load_vel = 1'b1;
								state_d      = ST_MSG;
							end
						end
						default: parse_d = PS_CMD;
					endcase
				end
			end
			ST_TICK: begin
				cmd.voice_step = 1'b1;
				cmd.mix_add    = (idx_q != '0);
				if (idx_q == LAST_VOICE) begin
					state_d = ST_SUM;
				end else begin
					idx_d = idx_q + VIDX_W'(1);
				end
			end
			ST_SUM: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_MSG: begin
				// owner lookup has landed; act on the message
				cmd.apply_msg = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase

		out_valid_d = out_valid_q && out_stall;
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end
	end

endmodule

>>> rtl/core/midi_four_voice_saw_synth.sv
// channel  signals                                        direction
// in       in_valid, in_stall, op, midi_byte              request in, stall out
// out      out_valid, out_stall, sample_out, busy_voices  request out, stall in
//
// Bytes go back to back; a full message's velocity byte stalls input in ST_MSG (owner RAM read).
// A tick runs ST_TICK, then ST_SUM; the voices are mixed one per cycle through one multiplier.
// The tick's result (the sample of the previous tick) is registered at acceptance.
// A tick is stalled while the previous result is still held by out_stall.
// Reset clears voice, parser and output state; per-note valid bits start the note table empty.
module midi_four_voice_saw_synth #(
	parameter int NUM_VOICES = mfvss_pkg::NUM_VOICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [7:0]                          midi_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mfvss_pkg::SAMPLE_W-1:0]      sample_out,
	output logic [mfvss_pkg::BUSY_OUT_W-1:0]    busy_voices
);

	import mfvss_pkg::*;

	`include "assert_macros.svh"

	localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	dp_cmd_t            cmd;
	byte_stat_t         stat;
	logic [VIDX_W-1:0]  voice_idx;
	logic               tick_acc;

	mfvss_ctrl #(
		.NUM_VOICES (NUM_VOICES),
		.VIDX_W     (VIDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.voice_idx (voice_idx)
	);

	mfvss_dp #(
		.NUM_VOICES (NUM_VOICES),
		.VIDX_W     (VIDX_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.voice_idx   (voice_idx),
		.midi_byte   (midi_byte),
		.stat        (stat),
		.sample_out  (sample_out),
		.busy_voices (busy_voices)
	);

	assign tick_acc = in_valid && !in_stall && !op;

	`ASSERT_NEXT(a_tick_result, tick_acc, out_valid, "tick gave no result")
	`ASSERT_NEXT(a_tick_busy, tick_acc, in_stall, "request taken during mix")
	`ASSERT_NEXT(a_sample_hold, !tick_acc, $stable(sample_out), "sample changed without tick")

endmodule

>>> tb/midi_four_voice_saw_synth_tb.sv
`timescale 1ns / 100ps
module midi_four_voice_saw_synth_tb;
	import mfvss_pkg::*;

	localparam int VOICES = NUM_VOICES_DEF;
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MIDI = 1'b1;
	localparam logic [7:0] CMD_PROG_CHANGE = 8'hC0;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD_CYCLES = 300;

	// phase increment per tick, one per note
	localparam logic [STEP_W-1:0] NOTE_RATE [NOTE_COUNT] = '{
		16'd11, 16'd11, 16'd12, 16'd13, 16'd14, 16'd14, 16'd15, 16'd16,
		16'd17, 16'd18, 16'd19, 16'd20, 16'd21, 16'd23, 16'd24, 16'd25,
		16'd27, 16'd29, 16'd30, 16'd32, 16'd34, 16'd36, 16'd38, 16'd40,
		16'd43, 16'd45, 16'd48, 16'd51, 16'd54, 16'd57, 16'd61, 16'd64,
		16'd68, 16'd72, 16'd76, 16'd81, 16'd86, 16'd91, 16'd96, 16'd102,
		16'd108, 16'd114, 16'd121, 16'd128, 16'd136, 16'd144, 16'd153, 16'd162,
		16'd171, 16'd182, 16'd192, 16'd204, 16'd216, 16'd229, 16'd242, 16'd257,
		16'd272, 16'd288, 16'd306, 16'd324, 16'd343, 16'd363, 16'd385, 16'd408,
		16'd432, 16'd458, 16'd485, 16'd514, 16'd544, 16'd577, 16'd611, 16'd647,
		16'd686, 16'd727, 16'd770, 16'd816, 16'd864, 16'd915, 16'd970, 16'd1028,
		16'd1089, 16'd1153, 16'd1222, 16'd1295, 16'd1372, 16'd1453, 16'd1540, 16'd1631,
		16'd1728, 16'd1831, 16'd1940, 16'd2055, 16'd2177, 16'd2307, 16'd2444, 16'd2589,
		16'd2743, 16'd2906, 16'd3079, 16'd3262, 16'd3456, 16'd3662, 16'd3880, 16'd4110,
		16'd4355, 16'd4614, 16'd4888, 16'd5179, 16'd5487, 16'd5813, 16'd6159, 16'd6525,
		16'd6913, 16'd7324, 16'd7759, 16'd8221, 16'd8710, 16'd9227, 16'd9776, 16'd10357,
		16'd10973, 16'd11626, 16'd12317, 16'd13050, 16'd13826, 16'd14648, 16'd15519, 16'd16441
	};

	typedef struct packed {
		logic [SAMPLE_W-1:0]   sample;
		logic [BUSY_OUT_W-1:0] busy;
	} tick_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  op;
	logic [7:0]            midi_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [SAMPLE_W-1:0]   sample_out;
	logic [BUSY_OUT_W-1:0] busy_voices;

	// predicted synth state
	logic [STEP_W-1:0]   exp_phase [VOICES];
	logic [STEP_W-1:0]   exp_rate [VOICES];
	logic [LEVEL_W-1:0]  exp_level [VOICES];
	logic                exp_on [VOICES];
	logic [2:0]          exp_owner [NOTE_COUNT];
	logic [VOICES-1:0]   exp_busy;
	parse_state_t        exp_stage;
	logic                exp_is_on;
	logic [NOTE_W-1:0]   exp_note;
	logic [SAMPLE_W-1:0] exp_next_sample;

	tick_result_t pending_samples [$];

	int  cycle_count = 0;
	int  mismatches = 0;
	int  results_checked = 0;
	int  ticks_sent = 0;
	int  bytes_sent = 0;
	int  hold_req = 0;
	bit  send_idle_en = 1'b1;
	bit  recv_idle_en = 1'b1;

	midi_four_voice_saw_synth #(
		.NUM_VOICES(VOICES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.midi_byte  (midi_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.busy_voices(busy_voices)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic synth_model_reset();
		for (int v = 0; v < VOICES; v++) begin
			exp_phase[v] = '0;
			exp_rate[v] = '0;
			exp_level[v] = '0;
			exp_on[v] = 1'b0;
		end
		for (int n = 0; n < NOTE_COUNT; n++)
			exp_owner[n] = '0;
		exp_busy = '0;
		exp_stage = PS_CMD;
		exp_is_on = 1'b0;
		exp_note = '0;
		exp_next_sample = '0;
	endtask

	task automatic synth_model_step(input logic is_midi, input logic [7:0] b);
		tick_result_t r;
		logic [STEP_W-1:0] p;
		logic [7:0] hi;
		logic [PROD_W-1:0] prod;
		logic [SAMPLE_W-1:0] mix;
		logic [2:0] own;
		bit placed;
		if (is_midi == OP_TICK) begin
			r.sample = exp_next_sample;
			r.busy = BUSY_OUT_W'(exp_busy);
			pending_samples.push_back(r);
			ticks_sent++;
			mix = '0;
			for (int v = 0; v < VOICES; v++) begin
				p = exp_phase[v] + exp_rate[v];
				exp_phase[v] = p;
				hi = exp_on[v] ? p[15:8] : 8'd0;
				prod = hi * exp_level[v];
				mix = mix + prod[PROD_W-1:8];
			end
			exp_next_sample = mix;
			return;
		end
		bytes_sent++;
		if (exp_stage == PS_CMD) begin
			if (b == MIDI_NOTE_OFF || b == MIDI_NOTE_ON) begin
				exp_is_on = (b == MIDI_NOTE_ON);
				exp_stage = PS_NOTE;
			end
		end else if (b[7]) begin
			// status byte in a data slot drops the message
			exp_stage = PS_CMD;
		end else if (exp_stage == PS_NOTE) begin
			exp_note = b[6:0];
			exp_stage = PS_VEL;
		end else begin
			exp_stage = PS_CMD;
			own = exp_owner[exp_note];
			if (!exp_is_on) begin
				if (own != 0) begin
					exp_rate[own-1] = '0;
					exp_level[own-1] = '0;
					exp_on[own-1] = 1'b0;
					exp_phase[own-1] = '0;
					exp_busy[own-1] = 1'b0;
					exp_owner[exp_note] = '0;
				end
			end else if (own == 0) begin
				placed = 1'b0;
				for (int v = VOICES - 1; v >= 0; v--) begin
					if (!placed && !exp_busy[v]) begin
						exp_owner[exp_note] = 3'(v + 1);
						exp_busy[v] = 1'b1;
						exp_rate[v] = NOTE_RATE[exp_note];
						exp_level[v] = b[6:1];
						exp_on[v] = 1'b1;
						placed = 1'b1;
					end
				end
			end
		end
	endtask

	// one request; returns at the edge where it is taken
	task automatic send_req(input logic is_midi, input logic [7:0] b);
		int gap;
		if (send_idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= is_midi;
		midi_byte <= b;
		do @(posedge clk); while (in_stall);
		synth_model_step(is_midi, b);
	endtask

	task automatic send_msg(input logic [7:0] cmd, input logic [7:0] note, input logic [7:0] vel);
		send_req(OP_MIDI, cmd);
		send_req(OP_MIDI, note);
		send_req(OP_MIDI, vel);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (VOICES + 4) @(posedge clk);
	endtask

	task automatic test_note_alloc();
		send_req(OP_TICK, 8'h00);
		send_msg(MIDI_NOTE_ON, 8'd0, 8'd127);    // lowest rate, full level
		send_msg(MIDI_NOTE_ON, 8'd127, 8'd0);    // zero velocity still takes a voice
		send_msg(MIDI_NOTE_ON, 8'd127, 8'd85);   // already sounding
		send_msg(MIDI_NOTE_ON, 8'd60, 8'd42);
		send_msg(MIDI_NOTE_ON, 8'd61, 8'd1);
		send_msg(MIDI_NOTE_ON, 8'd62, 8'd127);   // no free voice left
		send_req(OP_TICK, 8'hFF);
		send_msg(MIDI_NOTE_OFF, 8'd127, 8'd0);
		send_msg(MIDI_NOTE_OFF, 8'd5, 8'd64);    // note not sounding
		send_req(OP_TICK, 8'h5A);
	endtask

	task automatic test_parse_faults();
		send_req(OP_MIDI, CMD_PROG_CHANGE);
		send_req(OP_MIDI, MIDI_NOTE_OFF);
		send_req(OP_MIDI, 8'hFF);
		send_msg(MIDI_NOTE_ON, 8'h10, 8'h85);
		send_req(OP_TICK, 8'h00);
	endtask

	// receiver holds off long enough for ticks to back up into in_stall
	task automatic test_output_hold();
		send_idle_en = 1'b0;
		hold_req = LONG_HOLD_CYCLES;
		repeat (12) begin
			send_msg($urandom_range(0, 1) ? MIDI_NOTE_ON : MIDI_NOTE_OFF,
				8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
			repeat (3) send_req(OP_TICK, 8'($urandom));
		end
		send_idle_en = 1'b1;
	endtask

	task automatic test_sender_pause();
		repeat (5) send_req(OP_TICK, 8'($urandom));
		wait_drained();
		repeat (5) send_req(OP_TICK, 8'($urandom));
	endtask

	task automatic test_random_mix(input int target);
		int n;
		int r;
		logic [7:0] note_pool [8];
		logic [7:0] nt;
		for (int i = 0; i < 8; i++)
			note_pool[i] = 8'($urandom_range(0, 127));
		n = 0;
		while (n < target) begin
			r = $urandom_range(0, 99);
			// mostly a small pool so that note-offs find their note-ons
			nt = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 127))
				: note_pool[$urandom_range(0, 7)];
			if (r < 40) begin
				send_req(OP_TICK, 8'($urandom));
				n++;
			end else if (r < 62) begin
				send_msg(MIDI_NOTE_ON, nt, 8'($urandom_range(0, 127)));
				n += 3;
			end else if (r < 84) begin
				send_msg(MIDI_NOTE_OFF, nt, 8'($urandom_range(0, 127)));
				n += 3;
			end else if (r < 92) begin
				send_req(OP_MIDI, $urandom_range(0, 1) ? MIDI_NOTE_ON : MIDI_NOTE_OFF);
				n++;
				if ($urandom_range(0, 1)) begin
					send_req(OP_MIDI, nt);
					n++;
				end
				send_req(OP_MIDI, 8'($urandom_range(128, 255)));
				n++;
			end else begin
				send_req(OP_MIDI, 8'($urandom));
				n++;
			end
		end
	endtask

	// output side: random stall bursts plus the long hold-off
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (recv_idle_en && $urandom_range(0, 15) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected result, expected none, got sample_out=%0d busy_voices=%b",
					$time, sample_out, busy_voices);
				mismatches++;
			end else begin
				want = pending_samples.pop_front();
				results_checked++;
				if (sample_out !== want.sample) begin
					$display("%0t: sample_out expected %0d, got %0d", $time, want.sample, sample_out);
					mismatches++;
				end
				if (busy_voices !== want.busy) begin
					$display("%0t: busy_voices expected %b, got %b", $time, want.busy, busy_voices);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_samples.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_TICK;
		midi_byte <= 8'h00;
		synth_model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_note_alloc();
		test_parse_faults();
		test_output_hold();
		test_sender_pause();
		test_random_mix(1550);
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		test_random_mix(250);
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (4 * VOICES + 10) @(posedge clk);
		$display("Sent %0d ticks and %0d MIDI bytes, checked %0d samples", ticks_sent, bytes_sent,
			results_checked);
		$display("Voice allocation, parser faults, output hold-off and sender pauses exercised");
		if (mismatches == 0 && pending_samples.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mfvss_pkg.sv
rtl/core/mfvss_ram.sv
rtl/core/mfvss_dp.sv
rtl/core/mfvss_ctrl.sv
rtl/core/midi_four_voice_saw_synth.sv
tb/midi_four_voice_saw_synth_tb.sv
